// ===== rtl/jdm_pkg.sv =====
// Shared types and constants for the Jacobian distortion measure block.
// Used by jdm_isqrt and jacobian_distortion_measure; depends on nothing.
package jdm_pkg;

  localparam int unsigned JW         = 16;  // one Jacobian entry, Q4.12
  localparam int unsigned OUT_W      = 32;  // distortion, Q16.16
  localparam int unsigned NORM_W     = 33;  // sum of four squares
  localparam int unsigned SQRT_STEPS = 30;  // one root bit per stage
  localparam int unsigned ROOT_W     = SQRT_STEPS;
  localparam int unsigned RAD_W      = 2 * SQRT_STEPS;
  localparam int unsigned REM_W      = ROOT_W + 3;
  localparam int unsigned S_W        = 34;  // e'^2 + h'^2 in Q.24 units

  typedef enum logic [1:0] {
    MODE_CONFORMAL = 2'd0,
    MODE_ISOMETRIC = 2'd1,
    MODE_AUTHALIC  = 2'd2,
    MODE_NONE      = 2'd3
  } mode_e;

  // Data that rides beside the square root pipeline.
  typedef struct packed {
    mode_e               mode;
    logic [NORM_W-1:0]   norm2;  // ||J||^2 in Q.24 units
    logic [OUT_W-1:0]    val;    // finished Q16.16 result for modes 0 and 2
  } side_t;

endpackage

// ===== rtl/jdm_isqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Depends on jdm_pkg for widths and the side_t sideband struct.
module jdm_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [jdm_pkg::RAD_W-1:0]     in_rad_i,
  input  jdm_pkg::side_t                in_side_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [jdm_pkg::ROOT_W-1:0]    out_root_o,
  output jdm_pkg::side_t                out_side_o
);

  localparam int unsigned N = jdm_pkg::SQRT_STEPS;

  logic                          v_q    [N];
  logic [jdm_pkg::REM_W-1:0]     rem_q  [N];
  logic [jdm_pkg::ROOT_W-1:0]    root_q [N];
  logic [jdm_pkg::RAD_W-1:0]     rad_q  [N];
  jdm_pkg::side_t                side_q [N];
  logic [N:0]                    en;

  // A stage may load when it is empty or when the stage after it loads.
  always_comb begin
    en[N] = out_ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic                          pv;
    logic [jdm_pkg::REM_W-1:0]     prem;
    logic [jdm_pkg::ROOT_W-1:0]    proot;
    logic [jdm_pkg::RAD_W-1:0]     prad;
    jdm_pkg::side_t                pside;
    logic [jdm_pkg::REM_W-1:0]     rem_sh;
    logic [jdm_pkg::REM_W-1:0]     trial;
    logic [jdm_pkg::REM_W-1:0]     rem_d;
    logic [jdm_pkg::ROOT_W-1:0]    root_d;

    if (k == 0) begin : g_first
      assign pv    = in_valid_i;
      assign prem  = '0;
      assign proot = '0;
      assign prad  = in_rad_i;
      assign pside = in_side_i;
    end else begin : g_next
      assign pv    = v_q[k-1];
      assign prem  = rem_q[k-1];
      assign proot = root_q[k-1];
      assign prad  = rad_q[k-1];
      assign pside = side_q[k-1];
    end

    always_comb begin
      rem_sh = {prem[jdm_pkg::REM_W-3:0], prad[jdm_pkg::RAD_W-1-2*k -: 2]};
      trial  = {1'b0, proot, 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {proot[jdm_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {proot[jdm_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        rad_q[k]  <= prad;
        side_q[k] <= pside;
      end
    end
  end

  assign out_valid_o = v_q[N-1];
  assign out_root_o  = root_q[N-1];
  assign out_side_o  = side_q[N-1];

endmodule

// ===== rtl/jacobian_distortion_measure.sv =====
// Top level of the Jacobian distortion measure: input stages, products,
// the square root pipeline (jdm_isqrt) and the output register; uses jdm_pkg.
//
// Usage: one triangle's Jacobian enters per item on the slave stream, with
// s_axis_tdata = {j11, j10, j01, j00}, each signed Q4.12, j00 lowest. Each
// item yields exactly one item on the master stream: m_axis_tdata carries
// the distortion energy in unsigned Q16.16 and m_axis_tuser is set when
// that value was clipped at its maximum.
// The measure is chosen by the distortion_mode register at APB byte
// address 0 (0 conformal, 1 isometric, 2 authalic, 3 gives zero). Write it
// only while no items are in flight; it is sampled as each item enters.
// From acceptance to the master stream an item passes five input and
// arithmetic stages, thirty square root stages (one root bit each, set by
// the 60-bit radicand of the isometric measure) and the output register.
// Throughput is one item per cycle in every mode unless the master stalls.
// Each stage carries a valid bit and loads when it is empty or when the
// stage after it loads, so a stall on the master side fills bubbles first
// and never drops or repeats an item; s_axis_tready falls only when every
// stage holds an item. Reset empties the pipeline and sets the mode to 0.
module jacobian_distortion_measure (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // j00 [15:0], j01 [31:16], j10 [47:32], j11 [63:48]
  // Master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // distortion [31:0]
  output logic        m_axis_tuser,   // saturated [0]
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned JW = jdm_pkg::JW;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  jdm_pkg::mode_e mode_q;

  assign pready = 1'b1;
  assign prdata = {30'd0, mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jdm_pkg::MODE_CONFORMAL;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      mode_q <= jdm_pkg::mode_e'(pwdata[1:0]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage enables: a stage loads when empty or when its successor loads.
  // ---------------------------------------------------------------------
  logic f1_v_q, f2_v_q, f3_v_q, f4_v_q, f5_v_q, o_v_q;
  logic en1, en2, en3, en4, en5, en_o;
  logic sq_in_ready, sq_out_valid;

  assign en_o = !o_v_q || m_axis_tready;
  assign en5  = !f5_v_q || sq_in_ready;
  assign en4  = !f4_v_q || en5;
  assign en3  = !f3_v_q || en4;
  assign en2  = !f2_v_q || en3;
  assign en1  = !f1_v_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
      f4_v_q <= 1'b0;
      f5_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (en1)  f1_v_q <= s_axis_tvalid;
      if (en2)  f2_v_q <= f1_v_q;
      if (en3)  f3_v_q <= f2_v_q;
      if (en4)  f4_v_q <= f3_v_q;
      if (en5)  f5_v_q <= f4_v_q;
      if (en_o) o_v_q  <= sq_out_valid;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: register the Jacobian entries and the mode.
  // ---------------------------------------------------------------------
  logic signed [JW-1:0] f1_a_q, f1_b_q, f1_c_q, f1_d_q;
  jdm_pkg::mode_e       f1_mode_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      f1_a_q    <= s_axis_tdata[15:0];
      f1_b_q    <= s_axis_tdata[31:16];
      f1_c_q    <= s_axis_tdata[47:32];
      f1_d_q    <= s_axis_tdata[63:48];
      f1_mode_q <= mode_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: sums, differences, products and squares of the entries.
  // ---------------------------------------------------------------------
  logic signed [16:0] f2_dd_q, f2_ss_q, f2_ep_q, f2_hp_q;
  logic signed [31:0] f2_ad_q, f2_bc_q;
  logic [30:0]        f2_a2_q, f2_b2_q, f2_c2_q, f2_d2_q;
  jdm_pkg::mode_e     f2_mode_q;
  logic signed [31:0] a2_w, b2_w, c2_w, d2_w;

  always_comb begin
    a2_w = f1_a_q * f1_a_q;
    b2_w = f1_b_q * f1_b_q;
    c2_w = f1_c_q * f1_c_q;
    d2_w = f1_d_q * f1_d_q;
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      f2_dd_q   <= 17'(f1_a_q) - 17'(f1_d_q);
      f2_ss_q   <= 17'(f1_b_q) + 17'(f1_c_q);
      f2_ep_q   <= 17'(f1_a_q) + 17'(f1_d_q);
      f2_hp_q   <= 17'(f1_c_q) - 17'(f1_b_q);
      f2_ad_q   <= f1_a_q * f1_d_q;
      f2_bc_q   <= f1_b_q * f1_c_q;
      f2_a2_q   <= a2_w[30:0];
      f2_b2_q   <= b2_w[30:0];
      f2_c2_q   <= c2_w[30:0];
      f2_d2_q   <= d2_w[30:0];
      f2_mode_q <= f1_mode_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: squares of the combined terms, the norm and det J - 1.
  // ---------------------------------------------------------------------
  logic [33:0]                f3_conf_q;  // (a-d)^2 + (b+c)^2
  logic [jdm_pkg::S_W-1:0]    f3_s_q;     // (a+d)^2 + (c-b)^2
  logic [jdm_pkg::NORM_W-1:0] f3_norm_q;
  logic signed [33:0]         f3_det_q;
  jdm_pkg::mode_e             f3_mode_q;
  logic signed [33:0]         dd2_w, ss2_w, ep2_w, hp2_w;

  always_comb begin
    dd2_w = f2_dd_q * f2_dd_q;
    ss2_w = f2_ss_q * f2_ss_q;
    ep2_w = f2_ep_q * f2_ep_q;
    hp2_w = f2_hp_q * f2_hp_q;
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      f3_conf_q <= 34'(dd2_w[32:0]) + 34'(ss2_w[32:0]);
      f3_s_q    <= 34'(ep2_w[32:0]) + 34'(hp2_w[32:0]);
      f3_norm_q <= 33'(f2_a2_q) + 33'(f2_b2_q) + 33'(f2_c2_q) + 33'(f2_d2_q);
      f3_det_q  <= 34'(f2_ad_q) - 34'(f2_bc_q) - 34'sd16777216;
      f3_mode_q <= f2_mode_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: conformal result rounded to Q16.16 and |det J - 1|.
  // ---------------------------------------------------------------------
  logic [31:0]                f4_conf_q;
  logic [31:0]                f4_mdet_q;
  logic [jdm_pkg::S_W-1:0]    f4_s_q;
  logic [jdm_pkg::NORM_W-1:0] f4_norm_q;
  jdm_pkg::mode_e             f4_mode_q;
  logic [35:0]                conf_r_w;
  logic [33:0]                mdet_w;

  always_comb begin
    conf_r_w = {1'b0, f3_conf_q, 1'b0} + 36'd128;
    mdet_w   = f3_det_q[33] ? 34'(-f3_det_q) : 34'(f3_det_q);
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      f4_conf_q <= 32'(conf_r_w[35:8]);
      f4_mdet_q <= mdet_w[31:0];
      f4_s_q    <= f3_s_q;
      f4_norm_q <= f3_norm_q;
      f4_mode_q <= f3_mode_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: authalic square rounded to Q16.16; pick the early result.
  // ---------------------------------------------------------------------
  logic [jdm_pkg::S_W-1:0] f5_s_q;
  jdm_pkg::side_t          f5_side_q;
  logic [63:0]             auth_sq_w;
  logic [64:0]             auth_r_w;
  jdm_pkg::side_t          side5_d;

  always_comb begin
    auth_sq_w     = 64'(f4_mdet_q) * 64'(f4_mdet_q);
    auth_r_w      = {1'b0, auth_sq_w} + 65'h0_8000_0000;
    side5_d.mode  = f4_mode_q;
    side5_d.norm2 = f4_norm_q;
    case (f4_mode_q)
      jdm_pkg::MODE_CONFORMAL: side5_d.val = f4_conf_q;
      jdm_pkg::MODE_AUTHALIC:  side5_d.val = auth_r_w[63:32];
      default:                 side5_d.val = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      f5_s_q    <= f4_s_q;
      f5_side_q <= side5_d;
    end
  end

  // ---------------------------------------------------------------------
  // Square root of s * 2^24, one bit per stage.
  // ---------------------------------------------------------------------
  logic [jdm_pkg::RAD_W-1:0]  rad_w;
  logic [jdm_pkg::ROOT_W-1:0] sq_root;
  jdm_pkg::side_t             sq_side;

  assign rad_w = {2'b00, f5_s_q, 24'd0};

  jdm_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f5_v_q),
    .in_ready_o  (sq_in_ready),
    .in_rad_i    (rad_w),
    .in_side_i   (f5_side_q),
    .out_valid_o (sq_out_valid),
    .out_ready_i (en_o),
    .out_root_o  (sq_root),
    .out_side_o  (sq_side)
  );

  // ---------------------------------------------------------------------
  // Final stage: isometric energy, rounding, saturation, output register.
  // ||J||^2 - 2t + 2 in Q.24, clamped at zero, then rounded to Q16.16.
  // ---------------------------------------------------------------------
  logic signed [36:0] iso_w;
  logic [36:0]        iso_pos_w;
  logic [36:0]        iso_r_w;
  logic [31:0]        res_d;
  logic               sat_d;
  logic [31:0]        o_dist_q;
  logic               o_sat_q;

  always_comb begin
    iso_w     = 37'(sq_side.norm2) + 37'sd33554432 - 37'({sq_root, 1'b0});
    iso_pos_w = iso_w[36] ? 37'd0 : iso_w;
    iso_r_w   = (iso_pos_w + 37'd128) >> 8;
    res_d     = sq_side.val;
    sat_d     = 1'b0;
    case (sq_side.mode)
      jdm_pkg::MODE_ISOMETRIC: begin
        if (iso_r_w[36:32] != 5'd0) begin
          res_d = '1;
          sat_d = 1'b1;
        end else begin
          res_d = iso_r_w[31:0];
        end
      end
      jdm_pkg::MODE_NONE: res_d = '0;
      default:            res_d = sq_side.val;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      o_dist_q <= res_d;
      o_sat_q  <= sat_d;
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = o_dist_q;
  assign m_axis_tuser  = o_sat_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> f1_v_q)
    else $error("accepted item did not reach stage one");

  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !o_v_q |-> s_axis_tready)
    else $error("input stalled while the output register is empty");

  a_sat_is_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_v_q && o_sat_q) |-> (o_dist_q == 32'hFFFF_FFFF))
    else $error("saturated result is not the maximum value");

  a_mode_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_out_valid && en_o && sq_side.mode == jdm_pkg::MODE_NONE) |=>
      (o_dist_q == 32'd0 && !o_sat_q))
    else $error("mode three must give zero");

endmodule
